FILE: sv/wssh_pkg.sv
// shared constants, state encoding and modulo request type for the string hash unit
package wssh_pkg;

  localparam int CHAR_W    = 8;
  localparam int SUM_W     = 24;
  localparam int WEIGHT_W  = 15;
  localparam int CNT_W     = 11;
  localparam int PROD_W    = 37;
  localparam int MOD_STEPS = 37;
  localparam int MOD_CNT_W = 6;

  localparam logic [WEIGHT_W-1:0] WEIGHT_START = 15'd113;
  localparam logic [WEIGHT_W-1:0] WEIGHT_STEP  = 15'd22;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 15'd22641;
  localparam logic [CNT_W-1:0]    CHARS_CAP    = 11'd1024;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_MAX_CHARS  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_MUL,
    S_CHK,
    S_MOD,
    S_CNT,
    S_TMOD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [SUM_W-1:0]    modulus;
  } mod_req_t;

endpackage

FILE: sv/wssh_mod.sv
// bit-serial restoring modulo unit, one dividend bit per cycle
module wssh_mod
  import wssh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mod_req_t         req,
  output logic             done,
  output logic [SUM_W-1:0] rem
);

  logic [PROD_W-1:0]    div_r, div_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     m_r, m_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;

  always_comb begin
    trial    = {rem_r, div_r[PROD_W-1]};
    diff     = trial - {1'b0, m_r};
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      div_nxt  = req.dividend;
      rem_nxt  = '0;
      m_nxt    = req.modulus;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      div_nxt = {div_r[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, m_r}) begin
        rem_nxt = diff[SUM_W-1:0];
      end else begin
        rem_nxt = trial[SUM_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: sv/weighted_square_string_hash_unit.sv
// top level of the weighted-square string hash unit
//
// usage: characters arrive one per transfer on the in_ stream (in_tdata[7:0]);
// a zero character ends the string. each finished string gives one hash value
// on the out_ stream (out_tdata[23:0]). after max_chars characters (1 when
// max_chars is 0, at most 1024) the hash is sent at once and further
// characters up to the terminator are dropped; the terminator then gives no
// result. an empty string hashes to 0. a new character is taken only once
// the last one is through: the shift-add multiplier (weight squared, then
// times the character, ending early when the multiplier bits run out), then
// the 37-step restoring modulo loop when the new sum exceeds the modulus, then
// the emit state when it sends the early hash. a terminator waits for the
// modulo loop; a dropped character or a terminator after an early hash does not.
// out_tvalid rises from the emit state: after the modulo loop for a terminator,
// after the multiply for the character that reaches the limit.
// the result sits in an output register, so the next character is accepted
// while it waits; a second result waits inside the block until out_tready.
// configuration (cfg_we, cfg_index, cfg_wdata) is the user's to write between
// transfers; the block does not enforce it. reset (rst_n low, synchronous)
// clears the string state and restores table_size 65536 and max_chars 256.
module weighted_square_string_hash_unit
  import wssh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // hash_value[23:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     table_size_r, table_size_nxt;
  logic [CNT_W-1:0]     max_chars_r, max_chars_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [WEIGHT_W-1:0]  weight_r, weight_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 emitted_r, emitted_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [WEIGHT_W-1:0]  mplier_r, mplier_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]     res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]     out_data_r, out_data_nxt;

  logic [SUM_W-1:0]     modulus;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     cnt_inc;
  logic [WEIGHT_W-1:0]  weight_up;
  mod_req_t             mod_req;
  logic                 mod_done;
  logic [SUM_W-1:0]     mod_rem;

  wssh_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  assign modulus   = (table_size_r == '0) ? SUM_W'(1) : table_size_r;
  assign limit     = (max_chars_r == '0) ? CNT_W'(1) :
                     (max_chars_r > CHARS_CAP) ? CHARS_CAP : max_chars_r;
  assign cnt_inc   = cnt_r + 1'b1;
  assign weight_up = weight_r + WEIGHT_STEP;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    table_size_nxt = table_size_r;
    max_chars_nxt  = max_chars_r;
    sum_nxt        = sum_r;
    weight_nxt     = weight_r;
    cnt_nxt        = cnt_r;
    emitted_nxt    = emitted_r;
    ch_nxt         = ch_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = acc_r;
    mod_req.modulus  = modulus;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE: table_size_nxt = cfg_wdata;
        REG_MAX_CHARS:  max_chars_nxt  = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata == '0) begin
            mod_req.start    = !emitted_r;
            mod_req.dividend = {{(PROD_W-SUM_W){1'b0}}, sum_r};
            sum_nxt     = '0;
            weight_nxt  = WEIGHT_START;
            cnt_nxt     = '0;
            emitted_nxt = 1'b0;
            if (!emitted_r) begin
              state_nxt = S_TMOD;
            end
          end else if (!emitted_r) begin
            ch_nxt     = in_tdata;
            weight_nxt = weight_up;
            mcand_nxt  = {{(PROD_W-WEIGHT_W){1'b0}}, weight_up};
            mplier_nxt = weight_up;
            acc_nxt    = '0;
            state_nxt  = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mplier_r == '0) begin
          mcand_nxt  = acc_r;
          mplier_nxt = {{(WEIGHT_W-CHAR_W){1'b0}}, ch_r};
          acc_nxt    = '0;
          state_nxt  = S_MUL;
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[WEIGHT_W-1:1]};
        end
      end
      S_MUL: begin
        if (mplier_r == '0) begin
          acc_nxt   = acc_r + {{(PROD_W-SUM_W){1'b0}}, sum_r};
          state_nxt = S_CHK;
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[WEIGHT_W-1:1]};
        end
      end
      S_CHK: begin
        if (acc_r > {{(PROD_W-SUM_W){1'b0}}, modulus}) begin
          mod_req.start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          sum_nxt   = acc_r[SUM_W-1:0];
          state_nxt = S_CNT;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          sum_nxt   = mod_rem;
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= limit) begin
          emitted_nxt = 1'b1;
          res_nxt     = sum_r;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TMOD: begin
        if (mod_done) begin
          res_nxt   = mod_rem;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      table_size_r <= SUM_W'(65536);
      max_chars_r  <= CNT_W'(256);
      sum_r        <= '0;
      weight_r     <= WEIGHT_START;
      cnt_r        <= '0;
      emitted_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      table_size_r <= table_size_nxt;
      max_chars_r  <= max_chars_nxt;
      sum_r        <= sum_nxt;
      weight_r     <= weight_nxt;
      cnt_r        <= cnt_nxt;
      emitted_r    <= emitted_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ch_r       <= ch_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // weight stays within the span reached by the character cap
  assert property (@(posedge clk) disable iff (!rst_n)
    weight_r <= WEIGHT_MAX)
    else $error("weight beyond its bound");

  // the character count never passes the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CHARS_CAP)
    else $error("character count beyond cap");

  // a modulo result only arrives while a state is waiting for it
  assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD || state_r == S_TMOD))
    else $error("modulo result with nobody waiting");

  // a new result is only loaded from the emit state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

endmodule
